// ===== src/dlrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dlrs_pkg
// Shared types and constants for the decimal LSD radix sorter.
// ----------------------------------------------------------------------------
package dlrs_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int VALUE_BITS = 31;
  localparam int IDX_BITS   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);
  localparam int RADIX      = 10;
  localparam int DIG_BITS   = 4;
  localparam int WGT_BITS   = 34;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_MAX,
    ST_CHECK,
    ST_CLEAR,
    ST_COUNT,
    ST_PREFIX,
    ST_SCATTER,
    ST_COPY,
    ST_NEXT,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic                load;      // store the accepted word
    logic                clr_batch; // end of batch
    logic                idx_init;  // reset sweep index to 0
    logic                idx_top;   // reset sweep index to count-1
    logic                max_step;
    logic                clr_cnt;
    logic                cnt_step;
    logic                prefix_step;
    logic                scatter_step;
    logic                copy_step;
    logic                next_wgt;
    logic                emit_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sweep_done;  // index reached the end of the sweep
    logic more_digits; // max / weight > 0
    logic prefix_done;
    logic out_busy;    // output register full and not draining
  } stat_t;

endpackage

// ===== src/dlrs_if.sv =====
// ----------------------------------------------------------------------------
// dlrs_in_if / dlrs_out_if
// Valid/ready channels carrying input and result words.
// ----------------------------------------------------------------------------
interface dlrs_in_if;
  logic                               valid;
  logic                               ready;
  logic [dlrs_pkg::VALUE_BITS-1:0]    value;
  logic                               last;
  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

interface dlrs_out_if;
  logic                               valid;
  logic                               ready;
  logic [dlrs_pkg::VALUE_BITS-1:0]    sorted_value;
  logic                               end_of_batch;
  logic                               overflowed;
  modport source (output valid, sorted_value, end_of_batch, overflowed, input ready);
  modport sink   (input valid, sorted_value, end_of_batch, overflowed, output ready);
endinterface

// ===== src/decimal_lsd_radix_sorter_top.sv =====
// ----------------------------------------------------------------------------
// decimal_lsd_radix_sorter_top
// Batch sorter for up to 64 non-negative integers, base-10 LSD radix sort.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle until one marked last; the block then runs a
// max sweep and one counting-sort pass per decimal digit of the maximum, and
// streams the sorted batch out. Each word read in the count and scatter sweeps
// goes through a one-bit-per-cycle divider by the digit weight; a pass also
// copies the words back and clears and prefix-sums the digit counters. The
// emit stalls while the output is not ready; the input is not ready during
// sort and emit. Words past the 64th are dropped and flagged on every result
// of that batch.
module decimal_lsd_radix_sorter_top (
  input logic        clk,
  input logic        rst,
  dlrs_in_if.sink    in,
  dlrs_out_if.source out
);
  dlrs_pkg::cmd_t  cmd;
  dlrs_pkg::stat_t stat;
  logic            in_ready;

  assign in.ready = in_ready;

  dlrs_ctrl u_ctrl (
    .clk, .rst, .in_fire(in.valid && in_ready), .in_last(in.last),
    .stat, .in_ready, .cmd);

  dlrs_dp u_dp (.clk, .rst, .cmd, .in_value(in.value), .stat, .out);
endmodule

// ===== src/dlrs_ram.sv =====
// ----------------------------------------------------------------------------
// dlrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dlrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                 rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/dlrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlrs_ctrl
// Sequencer for load, max search, counting passes and emit.
// ----------------------------------------------------------------------------
module dlrs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_fire,
  input  logic             in_last,
  input  dlrs_pkg::stat_t  stat,
  output logic             in_ready,
  output dlrs_pkg::cmd_t   cmd
);
  dlrs_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dlrs_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dlrs_pkg::ST_LOAD:    if (in_fire && in_last) state_next = dlrs_pkg::ST_MAX;
      dlrs_pkg::ST_MAX:     if (stat.sweep_done) state_next = dlrs_pkg::ST_CHECK;
      dlrs_pkg::ST_CHECK:   state_next = stat.more_digits ? dlrs_pkg::ST_CLEAR
                                                          : dlrs_pkg::ST_EMIT;
      dlrs_pkg::ST_CLEAR:   state_next = dlrs_pkg::ST_COUNT;
      dlrs_pkg::ST_COUNT:   if (stat.sweep_done) state_next = dlrs_pkg::ST_PREFIX;
      dlrs_pkg::ST_PREFIX:  if (stat.prefix_done) state_next = dlrs_pkg::ST_SCATTER;
      dlrs_pkg::ST_SCATTER: if (stat.sweep_done) state_next = dlrs_pkg::ST_COPY;
      dlrs_pkg::ST_COPY:    if (stat.sweep_done) state_next = dlrs_pkg::ST_NEXT;
      dlrs_pkg::ST_NEXT:    state_next = dlrs_pkg::ST_CHECK;
      dlrs_pkg::ST_EMIT:    if (stat.sweep_done && !stat.out_busy)
                              state_next = dlrs_pkg::ST_LOAD;
      default:              state_next = dlrs_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dlrs_pkg::ST_LOAD: begin
        in_ready     = 1'b1;
        cmd.load     = in_fire;
        cmd.idx_init = in_fire && in_last;
      end
      dlrs_pkg::ST_MAX: begin
        cmd.max_step = 1'b1;
      end
      dlrs_pkg::ST_CHECK: begin
        cmd.idx_init = 1'b1;
      end
      dlrs_pkg::ST_CLEAR: begin
        cmd.clr_cnt  = 1'b1;
        cmd.idx_init = 1'b1;
      end
      dlrs_pkg::ST_COUNT: begin
        cmd.cnt_step = 1'b1;
        cmd.idx_top  = stat.sweep_done;
      end
      dlrs_pkg::ST_PREFIX: begin
        cmd.prefix_step = 1'b1;
      end
      dlrs_pkg::ST_SCATTER: begin
        cmd.scatter_step = 1'b1;
        cmd.idx_init     = stat.sweep_done;
      end
      dlrs_pkg::ST_COPY: begin
        cmd.copy_step = 1'b1;
      end
      dlrs_pkg::ST_NEXT: begin
        cmd.next_wgt = 1'b1;
      end
      dlrs_pkg::ST_EMIT: begin
        cmd.emit_step = !stat.out_busy;
        cmd.clr_batch = stat.sweep_done && !stat.out_busy;
      end
      default: ;
    endcase
  end
endmodule

// ===== src/dlrs_dp.sv =====
// ----------------------------------------------------------------------------
// dlrs_dp
// Stores, digit counters, weight and output register of the sorter.
// ----------------------------------------------------------------------------
module dlrs_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  dlrs_pkg::cmd_t                    cmd,
  input  logic [dlrs_pkg::VALUE_BITS-1:0]   in_value,
  output dlrs_pkg::stat_t                   stat,
  dlrs_out_if.source                        out
);
  localparam int VB = dlrs_pkg::VALUE_BITS;
  localparam int IB = dlrs_pkg::IDX_BITS;
  localparam int CB = dlrs_pkg::CNT_BITS;
  localparam int WB = dlrs_pkg::WGT_BITS;
  localparam int DB = dlrs_pkg::DIG_BITS;

  logic [CB-1:0] item_count;
  logic          drop_flag;
  logic [WB-1:0] digit_weight;
  logic [VB-1:0] top;
  logic [CB-1:0] idx;          // sweep index (read address)
  logic [CB-1:0] idx_d;        // index of word now on read data
  logic          rd_vld;       // read data valid this cycle
  logic [CB-1:0] digit_counts [dlrs_pkg::RADIX];
  logic [DB-1:0] pfx;

  logic [VB-1:0] w_rd, p_rd;
  logic [VB-1:0] v_s1;

  logic          w_we;
  logic [IB-1:0] w_wa;
  logic [VB-1:0] w_wd;
  logic          p_we;
  logic [IB-1:0] p_wa;

  logic          out_valid;
  logic [VB-1:0] out_val;
  logic          out_eob, out_ovf;

  logic [DB-1:0] dig;

  dlrs_ram #(.WIDTH(VB), .DEPTH(dlrs_pkg::MAX_ITEMS)) u_work (
    .clk, .we(w_we), .waddr(w_wa), .wdata(w_wd), .raddr(idx[IB-1:0]), .rdata(w_rd));
  dlrs_ram #(.WIDTH(VB), .DEPTH(dlrs_pkg::MAX_ITEMS)) u_pass (
    .clk, .we(p_we), .waddr(p_wa), .wdata(v_s1), .raddr(idx[IB-1:0]), .rdata(p_rd));

  // quotient by weight, one bit a cycle; the decimal digit of the quotient
  // is folded in as the bits come out (r = 2r + bit, minus ten when over)
  logic          div_busy, div_done, div_start;
  logic [5:0]    div_step;
  logic [WB-1:0] div_rem;
  logic [VB-1:0] div_num;
  logic [DB-1:0] div_r10;
  logic [WB-1:0] div_trial;
  logic          div_bit;
  logic [DB:0]   r10_dbl;

  logic          phase;  // a read is in flight for the current sweep step
  logic          sweep_on, issue;
  logic [CB-1:0] last_idx;
  logic          act;
  logic          step_fin;

  assign div_trial = {div_rem[WB-2:0], div_num[VB-1]};
  assign div_bit   = (div_trial >= digit_weight);
  assign r10_dbl   = {div_r10, div_bit};
  assign div_start = rd_vld && !div_busy && (cmd.cnt_step || cmd.scatter_step);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= div_busy && (div_step == 6'd0);
      if (div_start) begin
        div_busy <= 1'b1;
        div_num  <= w_rd;
        div_rem  <= '0;
        div_r10  <= '0;
        div_step <= 6'(VB);
      end else if (div_busy) begin
        if (div_step == 6'd0) begin
          div_busy <= 1'b0;
        end else begin
          div_rem  <= div_bit ? (div_trial - digit_weight) : div_trial;
          div_r10  <= (r10_dbl >= (DB+1)'(dlrs_pkg::RADIX))
                      ? DB'(r10_dbl - (DB+1)'(dlrs_pkg::RADIX)) : DB'(r10_dbl);
          div_num  <= {div_num[VB-2:0], 1'b0};
          div_step <= div_step - 6'd1;
        end
      end
    end
  end
  assign dig = div_r10;

  assign last_idx = item_count - CB'(1);

  // One word per step: issue read, wait for data, divide (count and scatter only), act.
  always_comb begin
    act = 1'b0;
    if (cmd.cnt_step || cmd.scatter_step) act = div_done;
    else if (cmd.max_step || cmd.copy_step || cmd.emit_step) act = rd_vld;
  end

  assign step_fin = (item_count == '0) || (act && idx_d == (cmd.scatter_step ? '0 : last_idx));
  assign stat.sweep_done  = step_fin;
  assign stat.more_digits = (WB'(top) >= digit_weight) && (top != '0);
  assign stat.prefix_done = (pfx == DB'(dlrs_pkg::RADIX - 1));
  assign stat.out_busy    = out_valid && !out.ready;

  assign v_s1 = w_rd;
  assign w_we = cmd.load ? (item_count < CB'(dlrs_pkg::MAX_ITEMS)) : (cmd.copy_step && act);
  assign w_wa = cmd.load ? item_count[IB-1:0] : idx_d[IB-1:0];
  assign w_wd = cmd.load ? in_value : p_rd;
  assign p_we = cmd.scatter_step && act;
  assign p_wa = IB'(digit_counts[dig] - CB'(1));

  assign sweep_on = (cmd.max_step || cmd.cnt_step || cmd.scatter_step || cmd.copy_step ||
                     cmd.emit_step) && item_count != '0;
  assign issue    = sweep_on && !phase;

  // read issue: hold address until word handled
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      phase  <= 1'b0;
    end else begin
      rd_vld <= issue;
      phase  <= sweep_on && (!phase || !act);
      if (issue) idx_d <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count   <= '0;
      drop_flag    <= 1'b0;
      digit_weight <= WB'(1);
      top          <= '0;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.emit_step && act) out_valid <= 1'b1;
      else if (out.ready) out_valid <= 1'b0;
      if (cmd.clr_batch) begin
        item_count <= '0;
        drop_flag  <= 1'b0;
      end else if (cmd.load) begin
        if (item_count < CB'(dlrs_pkg::MAX_ITEMS)) item_count <= item_count + CB'(1);
        else drop_flag <= 1'b1;
      end
      if (cmd.idx_init) idx <= '0;
      else if (cmd.idx_top) idx <= last_idx;
      else if (act && !step_fin) begin
        if (cmd.scatter_step) idx <= idx - CB'(1);
        else idx <= idx + CB'(1);
      end
      if (cmd.clr_batch) top <= '0;
      else if (cmd.max_step && act && w_rd > top) top <= w_rd;
      if (cmd.clr_cnt) begin
        for (int i = 0; i < dlrs_pkg::RADIX; i++) digit_counts[i] <= '0;
      end else if (cmd.cnt_step && act) begin
        digit_counts[dig] <= digit_counts[dig] + CB'(1);
      end else if (cmd.prefix_step && !stat.prefix_done) begin
        digit_counts[pfx + DB'(1)] <= digit_counts[pfx + DB'(1)] + digit_counts[pfx];
      end else if (p_we) begin
        digit_counts[dig] <= digit_counts[dig] - CB'(1);
      end
      if (cmd.clr_cnt) pfx <= '0;
      else if (cmd.prefix_step && !stat.prefix_done) pfx <= pfx + DB'(1);
      if (cmd.clr_batch) digit_weight <= WB'(1);
      else if (cmd.next_wgt) digit_weight <= (digit_weight << 3) + (digit_weight << 1);
      if (cmd.emit_step && act) begin
        out_val <= w_rd;
        out_eob <= (idx_d == last_idx);
        out_ovf <= drop_flag;
      end
    end
  end

  assign out.valid        = out_valid;
  assign out.sorted_value = out_val;
  assign out.end_of_batch = out_eob;
  assign out.overflowed   = out_ovf;
endmodule
